>>> hdl/ttcb_pkg.sv
`timescale 1ns / 1ps

package ttcb_pkg;

   // number formats
   localparam int SPEED_FRAC_BITS = 8;
   localparam int ANGLE_WIDTH     = 23;
   localparam int ANG_W           = ANGLE_WIDTH + 1;
   localparam int Q20_BITS        = 20;
   localparam int SPEED_W         = 16;
   localparam int RANGE_W         = 16;
   localparam int TTC_W           = 16;
   localparam int STEP_W          = 16;

   // cosine datapath
   localparam int TWO_PI_W  = 23;
   localparam int MAG_W     = (ANG_W > TWO_PI_W) ? ANG_W : TWO_PI_W;
   localparam int FOLD_W    = 21;
   localparam int X2_W      = 2 * FOLD_W - Q20_BITS;
   localparam int T_W       = Q20_BITS + 1;
   localparam int COS_W     = Q20_BITS + 2;
   localparam int RECIP_W   = 29;
   localparam int RECIP_SHIFT = 32;
   localparam int QUO_W     = X2_W + RECIP_W - RECIP_SHIFT;

   // divider
   localparam int PROD_W    = SPEED_W + COS_W;
   localparam int DIV_W     = PROD_W - 1 + TTC_W;
   localparam int NUM_SHIFT = SPEED_FRAC_BITS + Q20_BITS;
   localparam int CNT_W     = $clog2(TTC_W);

   localparam logic [MAG_W-1:0] TWO_PI_Q20  = MAG_W'(6588397);
   localparam logic [MAG_W-1:0] PI_Q20      = MAG_W'(3294199);
   localparam logic [MAG_W-1:0] HALF_PI_Q20 = MAG_W'(1647099);
   localparam logic [T_W-1:0]   Q20_ONE     = T_W'(1048576);
   localparam logic [TTC_W-1:0] TTC_INF     = '1;

   localparam logic signed [ANG_W-1:0] ANGLE_CEIL = {1'b0, {ANGLE_WIDTH{1'b1}}};

   // ceil(2^32 / d), exact floor division for 22-bit dividends
   localparam logic [RECIP_W-1:0] RECIP_56 = 29'd76695845;
   localparam logic [RECIP_W-1:0] RECIP_30 = 29'd143165577;
   localparam logic [RECIP_W-1:0] RECIP_12 = 29'd357913942;

   localparam logic [1:0] HORNER_FIRST  = 2'd0;
   localparam logic [1:0] HORNER_SECOND = 2'd1;
   localparam logic [1:0] HORNER_LAST   = 2'd2;

   localparam logic KIND_SPEED = 1'b0;
   localparam logic KIND_RANGE = 1'b1;

   // register file
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_START_ANGLE = 2'd0;
   localparam logic [1:0] REG_ANGLE_STEP  = 2'd1;
   localparam logic [1:0] REG_TTC_LIMIT   = 2'd2;

   localparam logic [ANGLE_WIDTH-1:0] START_ANGLE_RESET = ANGLE_WIDTH'(-2464153);
   localparam logic [STEP_W-1:0]      ANGLE_STEP_RESET  = STEP_W'(4574);
   localparam logic [TTC_W-1:0]       TTC_LIMIT_RESET   = TTC_W'(256);

   // beam queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic                      kind;
      logic signed [SPEED_W-1:0] forward_speed;
      logic [RANGE_W-1:0]        range_sample;
      logic                      last_beam;
   } req_word_type;

   typedef struct packed {
      logic               brake;
      logic [TTC_W-1:0]   min_ttc;
   } rsp_word_type;

   typedef struct packed {
      logic [RANGE_W-1:0]        range_sample;
      logic signed [SPEED_W-1:0] speed;
      logic signed [ANG_W-1:0]   angle;
      logic                      last_beam;
   } beam_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [RECIP_W-1:0] horner_recip(input logic [1:0] stage);
      logic [RECIP_W-1:0] r;
      case (stage)
         HORNER_FIRST: begin
            r = RECIP_56;
         end
         HORNER_SECOND: begin
            r = RECIP_30;
         end
         default: begin
            r = RECIP_12;
         end
      endcase
      return r;
   endfunction

endpackage

>>> hdl/ttcb_front.sv
`timescale 1ns / 1ps

module ttcb_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  ttcb_pkg::req_word_type              req_data,
   input  logic [ttcb_pkg::ANGLE_WIDTH-1:0]    start_angle,
   input  logic [ttcb_pkg::STEP_W-1:0]         angle_step,
   input  ttcb_pkg::queue_status_type          queue_status,
   output logic                                push,
   output ttcb_pkg::beam_type                  push_data
);

   logic signed [ttcb_pkg::SPEED_W-1:0] speed_ff, speed_in;
   logic signed [ttcb_pkg::ANG_W-1:0]   angle_ff, angle_in;
   logic                                in_scan_ff, in_scan_in;
   logic                                accept;
   logic signed [ttcb_pkg::ANG_W-1:0]   cur_angle;
   logic signed [ttcb_pkg::ANG_W:0]     angle_sum;

   assign req_ready = !queue_status.full;
   assign accept    = req_valid && req_ready;

   // first beam of a scan starts from the configured angle
   assign cur_angle = in_scan_ff ? angle_ff
                                 : $signed({start_angle[ttcb_pkg::ANGLE_WIDTH-1], start_angle});

   assign angle_sum = $signed({cur_angle[ttcb_pkg::ANG_W-1], cur_angle})
                    + $signed({{(ttcb_pkg::ANG_W + 1 - ttcb_pkg::STEP_W){1'b0}}, angle_step});

   always_comb begin
      speed_in   = speed_ff;
      angle_in   = angle_ff;
      in_scan_in = in_scan_ff;
      push       = 1'b0;
      if (accept) begin
         if (req_data.kind == ttcb_pkg::KIND_SPEED) begin
            speed_in = req_data.forward_speed;
         end else begin
            push       = 1'b1;
            in_scan_in = !req_data.last_beam;
            // saturate at the top of the angle range
            if (angle_sum > $signed({1'b0, ttcb_pkg::ANGLE_CEIL})) begin
               angle_in = ttcb_pkg::ANGLE_CEIL;
            end else begin
               angle_in = angle_sum[ttcb_pkg::ANG_W-1:0];
            end
         end
      end
   end

   always_comb begin
      push_data.range_sample = req_data.range_sample;
      push_data.speed        = speed_ff;
      push_data.angle        = cur_angle;
      push_data.last_beam    = req_data.last_beam;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff   <= '0;
         in_scan_ff <= 1'b0;
      end else begin
         speed_ff   <= speed_in;
         in_scan_ff <= in_scan_in;
      end
      angle_ff <= angle_in;
   end

endmodule

>>> hdl/ttcb_queue.sv
`timescale 1ns / 1ps

module ttcb_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  ttcb_pkg::beam_type          push_data,
   input  logic                        pop,
   output ttcb_pkg::beam_type          pop_data,
   output ttcb_pkg::queue_status_type  queue_status
);

   ttcb_pkg::beam_type                 slot_ff [ttcb_pkg::QUEUE_DEPTH];
   logic [ttcb_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [ttcb_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [ttcb_pkg::QCNT_W-1:0]        count_ff, count_in;

   function automatic logic [ttcb_pkg::QPTR_W-1:0] next_ptr(
      input logic [ttcb_pkg::QPTR_W-1:0] p);
      logic [ttcb_pkg::QPTR_W-1:0] n;
      if (p == ttcb_pkg::QPTR_W'(ttcb_pkg::QUEUE_DEPTH - 1)) begin
         n = '0;
      end else begin
         n = p + 1'b1;
      end
      return n;
   endfunction

   assign pop_data           = slot_ff[rd_ptr_ff];
   assign queue_status.full  = (count_ff == ttcb_pkg::QCNT_W'(ttcb_pkg::QUEUE_DEPTH));
   assign queue_status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/ttcb_back.sv
`timescale 1ns / 1ps

module ttcb_back (
   input  logic                        clock,
   input  logic                        reset,
   input  ttcb_pkg::queue_status_type  queue_status,
   output logic                        pop,
   input  ttcb_pkg::beam_type          pop_data,
   input  logic [ttcb_pkg::TTC_W-1:0]  ttc_limit,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output ttcb_pkg::rsp_word_type      rsp_data
);

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b000_0000_0001,
      ST_REDUCE = 11'b000_0000_0010,
      ST_FOLD   = 11'b000_0000_0100,
      ST_SQUARE = 11'b000_0000_1000,
      ST_RECIP  = 11'b000_0001_0000,
      ST_TMUL   = 11'b000_0010_0000,
      ST_COS    = 11'b000_0100_0000,
      ST_PROD   = 11'b000_1000_0000,
      ST_CHECK  = 11'b001_0000_0000,
      ST_DIV    = 11'b010_0000_0000,
      ST_UPDATE = 11'b100_0000_0000
   } back_state_type;

   back_state_type                        state_ff, state_in;
   logic [ttcb_pkg::MAG_W-1:0]            mag_ff, mag_in;
   logic                                  neg_ff, neg_in;
   logic [ttcb_pkg::X2_W-1:0]             x2_ff, x2_in;
   logic [ttcb_pkg::X2_W-1:0]             u_ff, u_in;
   logic [ttcb_pkg::T_W-1:0]              t_ff, t_in;
   logic [1:0]                            step_ff, step_in;
   logic signed [ttcb_pkg::SPEED_W-1:0]   speed_ff, speed_in;
   logic [ttcb_pkg::RANGE_W-1:0]          range_ff, range_in;
   logic                                  last_ff, last_in;
   logic signed [ttcb_pkg::COS_W-1:0]     cos_ff, cos_in;
   logic signed [ttcb_pkg::PROD_W-1:0]    prod_ff, prod_in;
   logic [ttcb_pkg::DIV_W-1:0]            rem_ff, rem_in;
   logic [ttcb_pkg::DIV_W-1:0]            dsh_ff, dsh_in;
   logic [ttcb_pkg::CNT_W-1:0]            cnt_ff, cnt_in;
   logic [ttcb_pkg::TTC_W-1:0]            ttc_ff, ttc_in;
   logic [ttcb_pkg::TTC_W-1:0]            min_ff, min_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   ttcb_pkg::rsp_word_type                rsp_data_ff, rsp_data_in;

   logic [ttcb_pkg::ANG_W-1:0]            abs_angle;
   logic [ttcb_pkg::MAG_W-1:0]            mag_half, mag_fold;
   logic [2*ttcb_pkg::FOLD_W-1:0]         sq;
   logic [ttcb_pkg::X2_W+ttcb_pkg::RECIP_W-1:0] rp;
   logic [ttcb_pkg::X2_W+ttcb_pkg::T_W-1:0]     tp;
   logic [ttcb_pkg::COS_W-1:0]            cos_pos;
   logic                                  slow;
   logic [ttcb_pkg::DIV_W-1:0]            den, num;
   logic                                  ge;
   logic [ttcb_pkg::TTC_W-1:0]            new_min;
   logic                                  slot_free;

   assign abs_angle = pop_data.angle[ttcb_pkg::ANG_W-1] ? (~pop_data.angle + 1'b1)
                                                        : pop_data.angle;
   // fold into [0, pi/2]
   assign mag_half = (mag_ff > ttcb_pkg::PI_Q20) ? (ttcb_pkg::TWO_PI_Q20 - mag_ff) : mag_ff;
   assign mag_fold = (mag_half > ttcb_pkg::HALF_PI_Q20) ? (ttcb_pkg::PI_Q20 - mag_half)
                                                        : mag_half;

   assign sq = mag_ff[ttcb_pkg::FOLD_W-1:0] * mag_ff[ttcb_pkg::FOLD_W-1:0];
   assign rp = u_ff * ttcb_pkg::horner_recip(step_ff);
   assign tp = x2_ff * t_ff;
   assign cos_pos = ttcb_pkg::COS_W'(ttcb_pkg::Q20_ONE) - ttcb_pkg::COS_W'(u_ff >> 1);

   // closing speed below two LSBs, or opening
   assign slow = prod_ff[ttcb_pkg::PROD_W-1]
              || (prod_ff[ttcb_pkg::PROD_W-2:ttcb_pkg::Q20_BITS+1] == '0);
   assign den  = ttcb_pkg::DIV_W'(prod_ff[ttcb_pkg::PROD_W-2:0]);
   assign num  = ttcb_pkg::DIV_W'(range_ff) << ttcb_pkg::NUM_SHIFT;
   assign ge   = (rem_ff >= dsh_ff);

   assign new_min   = (ttc_ff < min_ff) ? ttc_ff : min_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      x2_in        = x2_ff;
      u_in         = u_ff;
      t_in         = t_ff;
      step_in      = step_ff;
      speed_in     = speed_ff;
      range_in     = range_ff;
      last_in      = last_ff;
      cos_in       = cos_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      dsh_in       = dsh_ff;
      cnt_in       = cnt_ff;
      ttc_in       = ttc_ff;
      min_in       = min_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!queue_status.empty) begin
               pop      = 1'b1;
               mag_in   = ttcb_pkg::MAG_W'(abs_angle);
               speed_in = pop_data.speed;
               range_in = pop_data.range_sample;
               last_in  = pop_data.last_beam;
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (mag_ff >= ttcb_pkg::TWO_PI_Q20) begin
               mag_in = mag_ff - ttcb_pkg::TWO_PI_Q20;
            end else begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            mag_in   = mag_fold;
            neg_in   = (mag_half > ttcb_pkg::HALF_PI_Q20);
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            x2_in    = sq[ttcb_pkg::Q20_BITS +: ttcb_pkg::X2_W];
            u_in     = sq[ttcb_pkg::Q20_BITS +: ttcb_pkg::X2_W];
            step_in  = ttcb_pkg::HORNER_FIRST;
            state_in = ST_RECIP;
         end
         ST_RECIP: begin
            t_in     = ttcb_pkg::Q20_ONE
                     - ttcb_pkg::T_W'(rp[ttcb_pkg::RECIP_SHIFT +: ttcb_pkg::QUO_W]);
            state_in = ST_TMUL;
         end
         ST_TMUL: begin
            u_in = tp[ttcb_pkg::Q20_BITS +: ttcb_pkg::X2_W];
            if (step_ff == ttcb_pkg::HORNER_LAST) begin
               state_in = ST_COS;
            end else begin
               step_in  = step_ff + 1'b1;
               state_in = ST_RECIP;
            end
         end
         ST_COS: begin
            cos_in   = neg_ff ? -$signed(cos_pos) : $signed(cos_pos);
            state_in = ST_PROD;
         end
         ST_PROD: begin
            prod_in  = ttcb_pkg::PROD_W'(speed_ff) * ttcb_pkg::PROD_W'(cos_ff);
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (slow || (num >= (den << ttcb_pkg::TTC_W))) begin
               ttc_in   = ttcb_pkg::TTC_INF;
               state_in = ST_UPDATE;
            end else begin
               rem_in   = num;
               dsh_in   = den << (ttcb_pkg::TTC_W - 1);
               cnt_in   = ttcb_pkg::CNT_W'(ttcb_pkg::TTC_W - 1);
               ttc_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = ge ? (rem_ff - dsh_ff) : rem_ff;
            ttc_in = {ttc_ff[ttcb_pkg::TTC_W-2:0], ge};
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (last_ff) begin
               if (slot_free) begin
                  rsp_valid_in        = 1'b1;
                  rsp_data_in.brake   = (new_min <= ttc_limit);
                  rsp_data_in.min_ttc = new_min;
                  min_in              = ttcb_pkg::TTC_INF;
                  state_in            = ST_IDLE;
               end
            end else begin
               min_in   = new_min;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_ff       <= ttcb_pkg::TTC_INF;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_ff       <= min_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      x2_ff       <= x2_in;
      u_ff        <= u_in;
      t_ff        <= t_in;
      step_ff     <= step_in;
      speed_ff    <= speed_in;
      range_ff    <= range_in;
      last_ff     <= last_in;
      cos_ff      <= cos_in;
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      dsh_ff      <= dsh_in;
      cnt_ff      <= cnt_in;
      ttc_ff      <= ttc_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> hdl/ttc_emergency_brake_unit.sv
`timescale 1ns / 1ps
// Time-to-collision emergency brake.
// A range word is queued, then the back end runs range reduction, the cosine sequencer,
// the speed multiply and, unless the beam is slow or saturated, the 16-step divider; only
// the last beam of a scan gives a result, which waits while the result side stalls.
// The back end takes one range word at a time; speed words are taken while the queue has room.
// Reset (synchronous, active high): registers to defaults, speed zero, scan and queue empty.

module ttc_emergency_brake_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel: speed updates and range samples
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  ttcb_pkg::req_word_type               req_data,
   // response channel: one word per completed scan
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output ttcb_pkg::rsp_word_type               rsp_data,
   // register port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [ttcb_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [ttcb_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [ttcb_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);

   // -------------------------------------------------------------------------
   // Register file. Writes land in the access phase; no wait states.
   // Start angle changes apply to later scans (it is picked up at the first
   // beam of a scan); step and limit changes also reach a scan in progress.
   // -------------------------------------------------------------------------
   logic [ttcb_pkg::ANGLE_WIDTH-1:0] start_angle_ff, start_angle_in;
   logic [ttcb_pkg::STEP_W-1:0]      angle_step_ff, angle_step_in;
   logic [ttcb_pkg::TTC_W-1:0]       ttc_limit_ff, ttc_limit_in;
   logic [1:0]                       reg_index;
   logic                             csr_write;

   assign pready    = 1'b1;
   assign reg_index = paddr[ttcb_pkg::CSR_ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      start_angle_in = start_angle_ff;
      angle_step_in  = angle_step_ff;
      ttc_limit_in   = ttc_limit_ff;
      if (csr_write) begin
         case (reg_index)
            ttcb_pkg::REG_START_ANGLE: begin
               start_angle_in = pwdata[ttcb_pkg::ANGLE_WIDTH-1:0];
            end
            ttcb_pkg::REG_ANGLE_STEP: begin
               angle_step_in = pwdata[ttcb_pkg::STEP_W-1:0];
            end
            ttcb_pkg::REG_TTC_LIMIT: begin
               ttc_limit_in = pwdata[ttcb_pkg::TTC_W-1:0];
            end
            default: begin
               // unmapped: write dropped
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         ttcb_pkg::REG_START_ANGLE: begin
            prdata = ttcb_pkg::CSR_DATA_W'(start_angle_ff);
         end
         ttcb_pkg::REG_ANGLE_STEP: begin
            prdata = ttcb_pkg::CSR_DATA_W'(angle_step_ff);
         end
         ttcb_pkg::REG_TTC_LIMIT: begin
            prdata = ttcb_pkg::CSR_DATA_W'(ttc_limit_ff);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_angle_ff <= ttcb_pkg::START_ANGLE_RESET;
         angle_step_ff  <= ttcb_pkg::ANGLE_STEP_RESET;
         ttc_limit_ff   <= ttcb_pkg::TTC_LIMIT_RESET;
      end else begin
         start_angle_ff <= start_angle_in;
         angle_step_ff  <= angle_step_in;
         ttc_limit_ff   <= ttc_limit_in;
      end
   end

   // -------------------------------------------------------------------------
   // Front end: latches speed words, tags each range word with the current
   // speed and its beam angle, and pushes it into the beam queue.
   // -------------------------------------------------------------------------
   ttcb_pkg::queue_status_type queue_status;
   ttcb_pkg::beam_type         push_data;
   ttcb_pkg::beam_type         pop_data;
   logic                       push;
   logic                       pop;

   ttcb_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .start_angle  (start_angle_ff),
      .angle_step   (angle_step_ff),
      .queue_status (queue_status),
      .push         (push),
      .push_data    (push_data)
   );

   // Short beam queue decoupling the two halves.
   ttcb_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_data    (push_data),
      .pop          (pop),
      .pop_data     (pop_data),
      .queue_status (queue_status)
   );

   // -------------------------------------------------------------------------
   // Back end: cosine by range reduction and a 5-term polynomial, closing
   // speed multiply, restoring divide for TTC, running minimum, and the
   // registered response word.
   // -------------------------------------------------------------------------
   ttcb_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .pop          (pop),
      .pop_data     (pop_data),
      .ttc_limit    (ttc_limit_ff),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

   // -------------------------------------------------------------------------
   // Checks
   // -------------------------------------------------------------------------
   a_rsp_clear_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_brake_matches_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.brake == (rsp_data.min_ttc <= ttc_limit_ff)))
      else $error("brake flag disagrees with limit");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push && queue_status.full))
      else $error("beam queue overflow");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      queue_status.empty |-> !pop)
      else $error("beam queue underflow");

endmodule
